FILE: hw/rtl/point_light_distance_attenuation_unit_defines.svh
// assertion macros for the point light distance attenuation unit
`ifndef POINT_LIGHT_DISTANCE_ATTENUATION_UNIT_DEFINES_SVH
`define POINT_LIGHT_DISTANCE_ATTENUATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PLDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PLDA_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define PLDA_ASSERT(label, prop, msg)

`define PLDA_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

FILE: hw/rtl/plda_pkg.sv
// shared widths, constants, types and helpers of the attenuation pipeline
`timescale 1ns / 1ps
`default_nettype none

package plda_pkg;

  localparam int COORD_W    = 32;
  localparam int COEF_W     = 32;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DEN_W      = 48;
  localparam int WIDE_W     = DEN_W + 2;
  localparam int QUOT_W     = 16;
  localparam int DIV_REM_W  = DEN_W + 1;
  localparam int ATT_W      = QUOT_W + 1;
  localparam int CFG_IDX_W  = 3;

  localparam int FRONT_STAGES = 5;
  localparam int RECIP_PRE    = 3;

  localparam logic [DEN_W-1:0]  DEN_MAX = {DEN_W{1'b1}};
  localparam logic [ATT_W-1:0]  ATT_ONE = {1'b1, {QUOT_W{1'b0}}};
  localparam logic [COEF_W-1:0] CONST_COEF_RST = 32'h0001_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUADRATIC_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Z    = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0]         constant_coef;
    logic [COEF_W-1:0]         linear_coef;
    logic [COEF_W-1:0]         quadratic_coef;
    logic signed [COORD_W-1:0] light_pos_x;
    logic signed [COORD_W-1:0] light_pos_y;
    logic signed [COORD_W-1:0] light_pos_z;
  } plda_cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] dist_sq;
    logic [DEN_W-1:0] cterm;
  } plda_front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [DEN_W-1:0]  cterm;
  } plda_dist_t;

  function automatic logic [DEN_W-1:0] cap_den(input logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(DEN_MAX)) ? DEN_MAX : v[DEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/plda_front.sv
// front stages: axis distances, squared distance and quadratic term
`timescale 1ns / 1ps
`default_nettype none

module plda_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [plda_pkg::COORD_W-1:0]  in_x,
  input  logic signed [plda_pkg::COORD_W-1:0]  in_y,
  input  logic signed [plda_pkg::COORD_W-1:0]  in_z,
  input  plda_pkg::plda_cfg_t                  cfg,
  output logic                                 out_vld,
  output plda_pkg::plda_front_t                out_data
);
  import plda_pkg::*;

  function automatic logic [COORD_W-1:0] mag_diff(input logic signed [COORD_W-1:0] p,
                                                  input logic signed [COORD_W-1:0] l);
    logic signed [COORD_W:0] d;
    d = (COORD_W+1)'(p) - (COORD_W+1)'(l);
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  logic [FRONT_STAGES-1:0] vld_r;

  logic [COORD_W-1:0] mx_r, my_r, mz_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]   s3_r, s4_r, s5_r;
  logic [COEF_W+1:0]  p1_r;
  logic [SQ_W-1:0]    p2_r;
  logic [COEF_W-1:0]  p3hi_r;
  logic [DEN_W-1:0]   cterm_r;

  logic [SQ_W-1:0]    p3_full;
  logic [DEN_W-1:0]   t1, t2;
  logic [WIDE_W-1:0]  csum;

  always_comb begin
    p3_full = cfg.quadratic_coef * s3_r[COORD_W-1:0];
    t1 = (p1_r >= (COEF_W+2)'(ATT_ONE)) ? DEN_MAX : {p1_r[QUOT_W-1:0], {COORD_W{1'b0}}};
    t2 = (|p2_r[SQ_W-1:DEN_W]) ? DEN_MAX : p2_r[DEN_W-1:0];
    csum = WIDE_W'(t1) + WIDE_W'(t2) + WIDE_W'(p3hi_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= mag_diff(in_x, cfg.light_pos_x);
      my_r   <= mag_diff(in_y, cfg.light_pos_y);
      mz_r   <= mag_diff(in_z, cfg.light_pos_z);
      sqx_r  <= mx_r * mx_r;
      sqy_r  <= my_r * my_r;
      sqz_r  <= mz_r * mz_r;
      s3_r   <= SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
      s4_r   <= s3_r;
      p1_r   <= cfg.quadratic_coef * s3_r[SUM_W-1:SQ_W];
      p2_r   <= cfg.quadratic_coef * s3_r[SQ_W-1:COORD_W];
      p3hi_r <= p3_full[SQ_W-1:COORD_W];
      s5_r   <= s4_r;
      cterm_r <= cap_den(csum);
    end
  end

  assign out_vld          = vld_r[FRONT_STAGES-1];
  assign out_data.dist_sq = s5_r;
  assign out_data.cterm   = cterm_r;

endmodule

`default_nettype wire

FILE: hw/rtl/plda_sqrt.sv
// integer square root, one root bit per pipeline stage
`timescale 1ns / 1ps
`default_nettype none

module plda_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  plda_pkg::plda_front_t  in_data,
  output logic                   out_vld,
  output plda_pkg::plda_dist_t   out_data
);
  import plda_pkg::*;

  logic [SQRT_STEPS-1:0] vld_r;
  logic [REM_W-1:0]  rem_r   [SQRT_STEPS];
  logic [REM_W-1:0]  rem_nxt [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_nxt[SQRT_STEPS];
  logic [SUM_W-1:0]  pend_r  [SQRT_STEPS];
  logic [SUM_W-1:0]  pend_nxt[SQRT_STEPS];
  logic [DEN_W-1:0]  cterm_r [SQRT_STEPS];
  logic [DEN_W-1:0]  cterm_nxt[SQRT_STEPS];

  always_comb begin
    logic [REM_W-1:0]  rem_prev;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_prev;
    logic [SUM_W-1:0]  pend_prev;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      if (j == 0) begin
        rem_prev     = '0;
        root_prev    = '0;
        pend_prev    = in_data.dist_sq;
        cterm_nxt[j] = in_data.cterm;
      end else begin
        rem_prev     = rem_r[j-1];
        root_prev    = root_r[j-1];
        pend_prev    = pend_r[j-1];
        cterm_nxt[j] = cterm_r[j-1];
      end
      rem_sh = {rem_prev[REM_W-3:0], pend_prev[SUM_W-1 -: 2]};
      trial  = {1'b0, root_prev, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[j]  = rem_sh - trial;
        root_nxt[j] = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = rem_sh;
        root_nxt[j] = {root_prev[ROOT_W-2:0], 1'b0};
      end
      pend_nxt[j] = {pend_prev[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem_r[j]   <= rem_nxt[j];
        root_r[j]  <= root_nxt[j];
        pend_r[j]  <= pend_nxt[j];
        cterm_r[j] <= cterm_nxt[j];
      end
    end
  end

  assign out_vld           = vld_r[SQRT_STEPS-1];
  assign out_data.distance = root_r[SQRT_STEPS-1];
  assign out_data.cterm    = cterm_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/plda_recip.sv
// denominator assembly and pipelined reciprocal, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module plda_recip (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  plda_pkg::plda_dist_t         in_data,
  input  plda_pkg::plda_cfg_t          cfg,
  output logic                         out_vld,
  output logic [plda_pkg::ATT_W-1:0]   out_att
);
  import plda_pkg::*;

  localparam int DHI_W = ROOT_W - QUOT_W;

  logic [RECIP_PRE+QUOT_W-1:0] vld_r;

  logic [COEF_W+DHI_W-1:0]  pa_r;
  logic [COEF_W+QUOT_W-1:0] pb_r;
  logic [DEN_W-1:0]         cterm1_r, cterm2_r;
  logic [DEN_W-1:0]         bterm_r;
  logic [DEN_W-1:0]         den_r;
  logic                     small_r;
  logic [DEN_W-1:0]         den_nxt;

  logic [DIV_REM_W-1:0] drem_r   [QUOT_W];
  logic [DIV_REM_W-1:0] drem_nxt [QUOT_W];
  logic [QUOT_W-1:0]    quot_r   [QUOT_W];
  logic [QUOT_W-1:0]    quot_nxt [QUOT_W];
  logic [DEN_W-1:0]     dden_r   [QUOT_W];
  logic [DEN_W-1:0]     dden_nxt [QUOT_W];
  logic                 dsmall_r [QUOT_W];
  logic                 dsmall_nxt[QUOT_W];

  assign den_nxt = cap_den(WIDE_W'(cfg.constant_coef) + WIDE_W'(bterm_r) + WIDE_W'(cterm2_r));

  always_comb begin
    logic [DIV_REM_W-1:0] rem_prev;
    logic [DIV_REM_W-1:0] rem_sh;
    logic [QUOT_W-1:0]    quot_prev;
    for (int j = 0; j < QUOT_W; j++) begin
      if (j == 0) begin
        rem_prev      = DIV_REM_W'(ATT_ONE);
        quot_prev     = '0;
        dden_nxt[j]   = den_r;
        dsmall_nxt[j] = small_r;
      end else begin
        rem_prev      = drem_r[j-1];
        quot_prev     = quot_r[j-1];
        dden_nxt[j]   = dden_r[j-1];
        dsmall_nxt[j] = dsmall_r[j-1];
      end
      rem_sh = {rem_prev[DIV_REM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dden_nxt[j]}) begin
        drem_nxt[j] = rem_sh - {1'b0, dden_nxt[j]};
        quot_nxt[j] = {quot_prev[QUOT_W-2:0], 1'b1};
      end else begin
        drem_nxt[j] = rem_sh;
        quot_nxt[j] = {quot_prev[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RECIP_PRE+QUOT_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= cfg.linear_coef * in_data.distance[ROOT_W-1:QUOT_W];
      pb_r     <= cfg.linear_coef * in_data.distance[QUOT_W-1:0];
      cterm1_r <= in_data.cterm;
      bterm_r  <= cap_den(WIDE_W'(pa_r) + WIDE_W'(pb_r[COEF_W+QUOT_W-1:QUOT_W]));
      cterm2_r <= cterm1_r;
      den_r    <= den_nxt;
      small_r  <= (den_nxt <= DEN_W'(ATT_ONE));
      for (int j = 0; j < QUOT_W; j++) begin
        drem_r[j]   <= drem_nxt[j];
        quot_r[j]   <= quot_nxt[j];
        dden_r[j]   <= dden_nxt[j];
        dsmall_r[j] <= dsmall_nxt[j];
      end
    end
  end

  // denominator at or below one gives full intensity
  assign out_vld = vld_r[RECIP_PRE+QUOT_W-1];
  assign out_att = dsmall_r[QUOT_W-1] ? ATT_ONE : {1'b0, quot_r[QUOT_W-1]};

endmodule

`default_nettype wire

FILE: hw/rtl/plda_outbuf.sv
// output register with skid entry, holds the pipeline when both are full
`timescale 1ns / 1ps
`default_nettype none

module plda_outbuf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pipe_vld,
  input  logic [plda_pkg::ATT_W-1:0]  pipe_att,
  output logic                        pipe_en,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [plda_pkg::ATT_W-1:0]  out_attenuation
);
  import plda_pkg::*;

  logic             out_vld_r, skid_vld_r;
  logic [ATT_W-1:0] out_att_r, skid_att_r;
  logic             out_free;

  assign out_free = !out_vld_r || !out_stall;
  assign pipe_en  = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= pipe_vld;
      end
    end else if (pipe_vld && pipe_en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_att_r <= skid_vld_r ? skid_att_r : pipe_att;
    end else if (pipe_en) begin
      skid_att_r <= pipe_att;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_attenuation = out_att_r;

endmodule

`default_nettype wire

FILE: hw/rtl/point_light_distance_attenuation_unit.sv
// Point light distance attenuation, f = min(1, 1/(a + b*d + c*d^2)).
// Input channel in_valid/in_stall carries a surface point (signed Q16.16 x, y, z);
// result channel out_valid/out_stall carries attenuation as unsigned Q1.16
// (65536 is 1.0). An item moves at a clock edge with valid high and stall low.
// Coefficients and light position are written through cfg_wr_en/cfg_index/
// cfg_data; the user must write them only while no item is in flight, which the
// block does not enforce. Indexes past the list are ignored. Throughput: one
// item per cycle while the pipeline is not held. An item passes 5 distance
// stages, 33 square root stages (one root bit per stage), 3 denominator stages,
// 16 reciprocal stages (one quotient bit per stage) and the output register.
// When the receiver stalls, the output register holds and one further item
// lands in a skid entry; in_stall then rises and the whole pipeline holds
// until the skid entry drains. No item is lost or repeated.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults: constant term 1.0, other terms and light position zero.
`timescale 1ns / 1ps
`default_nettype none
`include "point_light_distance_attenuation_unit_defines.svh"

module point_light_distance_attenuation_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [plda_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [plda_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [plda_pkg::COORD_W-1:0]   in_point_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [plda_pkg::ATT_W-1:0]            out_attenuation,
  input  logic                                  cfg_wr_en,
  input  logic [plda_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [plda_pkg::COEF_W-1:0]           cfg_data
);
  import plda_pkg::*;

  plda_cfg_t   cfg_r;
  logic        pipe_en;
  logic        front_vld, dist_vld, recip_vld;
  plda_front_t front_data;
  plda_dist_t  dist_data;
  logic [ATT_W-1:0] recip_att;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.constant_coef  <= CONST_COEF_RST;
      cfg_r.linear_coef    <= '0;
      cfg_r.quadratic_coef <= '0;
      cfg_r.light_pos_x    <= '0;
      cfg_r.light_pos_y    <= '0;
      cfg_r.light_pos_z    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CONSTANT_COEF:  cfg_r.constant_coef  <= cfg_data;
        CFG_LINEAR_COEF:    cfg_r.linear_coef    <= cfg_data;
        CFG_QUADRATIC_COEF: cfg_r.quadratic_coef <= cfg_data;
        CFG_LIGHT_POS_X:    cfg_r.light_pos_x    <= $signed(cfg_data);
        CFG_LIGHT_POS_Y:    cfg_r.light_pos_y    <= $signed(cfg_data);
        CFG_LIGHT_POS_Z:    cfg_r.light_pos_z    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_stall = !pipe_en;

  plda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (in_valid),
    .in_x     (in_point_x),
    .in_y     (in_point_y),
    .in_z     (in_point_z),
    .cfg      (cfg_r),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  plda_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (dist_vld),
    .out_data (dist_data)
  );

  plda_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (dist_vld),
    .in_data  (dist_data),
    .cfg      (cfg_r),
    .out_vld  (recip_vld),
    .out_att  (recip_att)
  );

  plda_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .pipe_vld        (recip_vld),
    .pipe_att        (recip_att),
    .pipe_en         (pipe_en),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_attenuation (out_attenuation)
  );

  `PLDA_ASSERT(a_att_range, out_valid |-> (out_attenuation <= ATT_ONE), "attenuation above one")
  `PLDA_ASSERT(a_skid_needs_out, in_stall |-> out_valid, "skid entry full with empty output")
  `PLDA_ASSERT_NEXT(a_skid_cause, !in_stall && !(out_valid && out_stall), !in_stall, "skid filled without stall")

endmodule

`default_nettype wire

FILE: test/tb_point_light_distance_attenuation_unit.sv
// self-checking testbench for the point light distance attenuation unit
`timescale 1ns / 1ps

module tb_point_light_distance_attenuation_unit;
  import plda_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [47:0] DEN_CEIL = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] UNITY_Q16 = 48'd65536;
  localparam logic [ATT_W-1:0] FULL_LIGHT = 17'h1_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_TWO = 32'sh0002_0000;
  localparam logic signed [31:0] Q_THREE = 32'sh0003_0000;
  localparam logic signed [31:0] Q_FOUR = 32'sh0004_0000;
  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SWEEP_PHASES = 10;
  localparam int POINTS_PER_PHASE = 113;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ATT_W-1:0] out_attenuation;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // register shadow
  logic [31:0] coef_const = 32'h0001_0000;
  logic [31:0] coef_lin = '0;
  logic [31:0] coef_quad = '0;
  logic signed [31:0] light_x = '0, light_y = '0, light_z = '0;

  logic [ATT_W-1:0] pending_atten_q[$];
  logic [ATT_W-1:0] want_atten;
  int fault_count = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit sender_pauses = 1'b1;
  bit receiver_pauses = 1'b1;

  always #5 clk = ~clk;

  point_light_distance_attenuation_unit dut (.*);

  function automatic logic [32:0] axis_gap(input logic signed [31:0] p,
                                           input logic signed [31:0] l);
    logic [32:0] diff;
    diff = {p[31], p} - {l[31], l};
    return diff[32] ? (~diff + 33'd1) : diff;
  endfunction

  function automatic logic [ATT_W-1:0] predict_attenuation(input logic signed [31:0] px,
                                                           input logic signed [31:0] py,
                                                           input logic signed [31:0] pz);
    logic [32:0] gx, gy, gz;
    logic [65:0] dist_sq;
    logic [33:0] dist_q16, trial;
    logic [69:0] trial_w;
    logic [111:0] den_full;
    logic [47:0] den;
    logic [63:0] quotient;
    gx = axis_gap(px, light_x);
    gy = axis_gap(py, light_y);
    gz = axis_gap(pz, light_z);
    dist_sq = gx * gx + gy * gy + gz * gz;
    dist_q16 = '0;
    for (int bitpos = 33; bitpos >= 0; bitpos--) begin
      trial = dist_q16 | (34'd1 << bitpos);
      trial_w = trial;
      if (trial_w * trial_w <= dist_sq) dist_q16 = trial;
    end
    den_full = coef_const + ((coef_lin * dist_q16) >> 16) + ((coef_quad * dist_sq) >> 32);
    den = (den_full > DEN_CEIL) ? DEN_CEIL : den_full[47:0];
    if (den <= UNITY_Q16) return FULL_LIGHT;
    quotient = 64'h1_0000_0000 / den;
    return quotient[ATT_W-1:0];
  endfunction

  function automatic logic [31:0] spread_word();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // mostly near the light, sometimes anywhere
  function automatic logic signed [31:0] scatter_coord(input logic signed [31:0] centre);
    logic [31:0] offset;
    if ($urandom_range(0, 3) == 0) return $urandom;
    offset = $urandom >> $urandom_range(8, 31);
    return $urandom_range(0, 1) ? centre + offset : centre - offset;
  endfunction

  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_pauses = !sender_pauses;
    gap = sender_pauses ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (in_stall);
    pending_atten_q.push_back(predict_attenuation(px, py, pz));
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_atten_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_CONSTANT_COEF: coef_const = value;
      CFG_LINEAR_COEF: coef_lin = value;
      CFG_QUADRATIC_COEF: coef_quad = value;
      CFG_LIGHT_POS_X: light_x = value;
      CFG_LIGHT_POS_Y: light_y = value;
      CFG_LIGHT_POS_Z: light_z = value;
      default: ;
    endcase
  endtask

  task automatic load_light(input logic signed [31:0] lx, input logic signed [31:0] ly,
                            input logic signed [31:0] lz);
    load_register(CFG_LIGHT_POS_X, lx);
    load_register(CFG_LIGHT_POS_Y, ly);
    load_register(CFG_LIGHT_POS_Z, lz);
  endtask

  task automatic test_reset_defaults();
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, Q_HALF);
    settle_pipeline();
  endtask

  task automatic test_special_cases();
    // zero denominator
    load_register(CFG_CONSTANT_COEF, 32'd0);
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    settle_pipeline();
    // just above 1.0
    load_register(CFG_CONSTANT_COEF, 32'h0001_0001);
    send_point(Q_ONE, '0, '0);
    settle_pipeline();
    load_register(CFG_CONSTANT_COEF, 32'h0002_0000);
    send_point('0, Q_ONE, '0);
    settle_pipeline();
    // linear term only
    load_register(CFG_CONSTANT_COEF, 32'd0);
    load_register(CFG_LINEAR_COEF, Q_ONE);
    send_point(Q_THREE, Q_FOUR, '0);
    send_point(Q_HALF, '0, '0);
    settle_pipeline();
    // quadratic term only, denominator exactly 1.0 first
    load_register(CFG_LINEAR_COEF, 32'd0);
    load_register(CFG_QUADRATIC_COEF, Q_ONE);
    send_point(Q_ONE, '0, '0);
    send_point(Q_TWO, '0, '0);
    send_point(-Q_TWO, -Q_TWO, -Q_ONE);
    settle_pipeline();
    // farthest point, saturated denominator
    load_light(COORD_MAX, COORD_MAX, COORD_MAX);
    load_register(CFG_QUADRATIC_COEF, 32'hFFFF_FFFF);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    settle_pipeline();
    load_register(CFG_QUADRATIC_COEF, 32'd0);
    load_register(CFG_LINEAR_COEF, 32'hFFFF_FFFF);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    settle_pipeline();
    load_register(CFG_CONSTANT_COEF, 32'hFFFF_FFFF);
    load_register(CFG_LINEAR_COEF, 32'd0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    settle_pipeline();
    // writes past the register list must not land anywhere
    load_register(CFG_SPARE_LO, 32'd0);
    load_register(CFG_SPARE_HI, 32'h1234_5678);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MAX - Q_ONE, COORD_MAX, COORD_MAX);
    settle_pipeline();
    load_light(COORD_MIN, COORD_MIN, COORD_MIN);
    load_register(CFG_CONSTANT_COEF, Q_ONE);
    load_register(CFG_QUADRATIC_COEF, 32'd1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    settle_pipeline();
  endtask

  task automatic test_random_sweep();
    logic [31:0] a_val, b_val, c_val;
    logic signed [31:0] lx, ly, lz;
    for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
      case (phase)
        0: begin
          a_val = '0;
          b_val = '0;
          c_val = '0;
          lx = $urandom;
          ly = $urandom;
          lz = $urandom;
        end
        1: begin
          a_val = '1;
          b_val = '1;
          c_val = '1;
          lx = COORD_MAX;
          ly = COORD_MAX;
          lz = COORD_MAX;
        end
        2: begin
          a_val = Q_ONE;
          b_val = '0;
          c_val = spread_word();
          lx = COORD_MIN;
          ly = COORD_MIN;
          lz = COORD_MIN;
        end
        default: begin
          a_val = spread_word();
          b_val = spread_word();
          c_val = spread_word();
          lx = $urandom;
          ly = $urandom;
          lz = $urandom;
        end
      endcase
      load_register(CFG_CONSTANT_COEF, a_val);
      load_register(CFG_LINEAR_COEF, b_val);
      load_register(CFG_QUADRATIC_COEF, c_val);
      load_light(lx, ly, lz);
      repeat (POINTS_PER_PHASE) begin
        send_point(scatter_coord(light_x), scatter_coord(light_y), scatter_coord(light_z));
      end
      settle_pipeline();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_atten_q.size() == 0) begin
          $display("%0t: attenuation item %0d with none pending", $time, out_attenuation);
          fault_count++;
        end else begin
          want_atten = pending_atten_q.pop_front();
          if (out_attenuation !== want_atten) begin
            $display("%0t: attenuation mismatch, expected %0d, actual %0d",
                     $time, want_atten, out_attenuation);
            fault_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) receiver_pauses = !receiver_pauses;
        stall_left = receiver_pauses ? $urandom_range(0, 3) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_random_sweep();
    settle_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: point_light_distance_attenuation_unit.f
+incdir+hw/rtl
hw/rtl/plda_pkg.sv
hw/rtl/plda_front.sv
hw/rtl/plda_sqrt.sv
hw/rtl/plda_recip.sv
hw/rtl/plda_outbuf.sv
hw/rtl/point_light_distance_attenuation_unit.sv
test/tb_point_light_distance_attenuation_unit.sv
